// ----- src/cpct_pkg.sv -----
// Shared constants and elaboration-time tables for the correlation peak tracker.
package cpct_pkg;

  localparam int KEY_COUNT = 256;
  localparam int KEY_W     = $clog2(KEY_COUNT);

  localparam logic [30:0] INV_LN2_Q30   = 31'd1549082005;
  localparam logic [30:0] Q30_ONE       = 31'd1073741824;
  localparam logic [15:0] QHW_RESET     = 16'd8028;
  localparam logic [31:0] FEWEST_TRACES = 32'd3;

  typedef logic [15:0][29:0] ctab_t;

  // bitwise integer square root, evaluated only at elaboration
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x     = x_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bit_v) begin
        x   = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-(16-i)) in Q30 for fraction bit i
  function automatic ctab_t build_ctab();
    ctab_t       tab;
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int i = 15; i >= 0; i--) begin
      tab[i] = c[29:0];
      c      = isqrt64(c << 30);
    end
    return tab;
  endfunction

  localparam ctab_t POW_C = build_ctab();

endpackage

// ----- src/correlation_peak_confidence_tracker.sv -----
// Correlation peak tracker: per-key peak store, top-two scan and Fisher-z bounds.
// Sample beat: a read, then a conditional write in the update state; busy meanwhile.
// End-of-block beat: a scan of the whole store, then bounds work on one shared
// multiplier and one shared 64-bit subtract/compare unit (the bounds work is skipped
// when fewer than four traces). One result strobe, busy until it has gone.
// Reset (synchronous, rst_n low) empties the store via its valid bits and loads 8028
// into the quantile register; the store empties likewise after each block.
module correlation_peak_confidence_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [cpct_pkg::KEY_W-1:0]  in_key_index,
  input  logic signed [15:0]          in_corr_value,
  input  logic [31:0]                 in_trace_count,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_wdata,
  output logic                        out_valid,
  output logic [15:0]                 out_best_value,
  output logic [7:0]                  out_best_key,
  output logic signed [15:0]          out_best_lower,
  output logic signed [15:0]          out_best_upper,
  output logic [15:0]                 out_second_value,
  output logic signed [15:0]          out_second_lower,
  output logic signed [15:0]          out_second_upper,
  output logic                        out_too_few_traces,
  output logic [31:0]                 out_traces_echo
);
  import cpct_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_UPD   = 4'd1;
  localparam logic [3:0] ST_SCAN  = 4'd2;
  localparam logic [3:0] ST_SQRT  = 4'd3;
  localparam logic [3:0] ST_EMUL  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_ESET  = 4'd6;
  localparam logic [3:0] ST_LINIT = 4'd7;
  localparam logic [3:0] ST_LOG   = 4'd8;
  localparam logic [3:0] ST_PINIT = 4'd9;
  localparam logic [3:0] ST_POW   = 4'd10;
  localparam logic [3:0] ST_PSH   = 4'd11;
  localparam logic [3:0] ST_TFIN  = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  localparam int CNT_W = KEY_W + 1;

  logic [3:0]           state_r, state_nxt;
  logic [15:0]          h_r;
  logic [KEY_COUNT-1:0] vld_r;
  logic [15:0]          mem [KEY_COUNT];
  logic [15:0]          rd_q;
  logic [KEY_W-1:0]     rd_addr;
  logic                 wr_en;

  logic [KEY_W-1:0]     key_r;
  logic [15:0]          mag_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 scan_v_r;
  logic [KEY_W-1:0]     scan_idx_r;
  logic [15:0]          bv_r, sv_r;
  logic [KEY_W-1:0]     bi_r;
  logic [31:0]          n_r;
  logic                 few_r;

  logic [63:0]          rem_r, dq_r, dv_r;
  logic [5:0]           it_r;
  logic                 div_e_r;
  logic [23:0]          e_r;
  logic [30:0]          x_r;
  logic [3:0]           lm_r;
  logic [15:0]          frac_r;
  logic [19:0]          la_r;
  logic [19:0]          d_r;
  logic                 lhalf_r, sel_r, bsel_r, neg_r;
  logic [15:0]          a_r;
  logic [8:0]           k_r;
  logic [30:0]          p_r;
  logic signed [15:0]   bl_r, bh_r, sl_r, sh_r;

  // shared multiplier
  logic [30:0] mul_a, mul_b;
  logic [61:0] prod;

  always_comb begin
    unique case (state_r)
      ST_LOG:  begin mul_a = x_r;               mul_b = x_r;                    end
      ST_POW:  begin mul_a = p_r;               mul_b = {1'b0, POW_C[it_r[3:0]]}; end
      ST_EMUL: begin mul_a = {15'd0, h_r};      mul_b = INV_LN2_Q30;            end
      default: begin mul_a = '0;                mul_b = '0;                     end
    endcase
  end
  assign prod = 62'(mul_a) * 62'(mul_b);

  // shared subtract/compare
  logic [64:0] cmp_a, cmp_b, diff;
  logic        ge;
  always_comb begin
    if (state_r == ST_SQRT) begin
      cmp_a = {1'b0, rem_r};
      cmp_b = {1'b0, dq_r + dv_r};
    end else begin
      cmp_a = {rem_r, dq_r[63]};
      cmp_b = {1'b0, dv_r};
    end
  end
  assign diff = cmp_a - cmp_b;
  assign ge   = ~diff[64];

  // beat acceptance and input magnitude
  logic        acc;
  logic [15:0] in_mag;
  assign acc    = start && !busy;
  assign in_mag = in_corr_value[15] ? 16'(~in_corr_value + 16'sd1) : in_corr_value;

  // stored peak with valid bit applied
  logic [15:0] cur_v;
  assign cur_v = vld_r[(state_r == ST_SCAN) ? scan_idx_r : key_r] ? rd_q : 16'd0;

  // log2 operand and msb position
  logic [15:0] r_lim, lv;
  logic [3:0]  lv_m;
  always_comb begin
    r_lim = (sel_r ? sv_r : bv_r);
    if (r_lim > 16'd32767) r_lim = 16'd32767;
    lv   = lhalf_r ? (16'd32768 - r_lim) : (16'd32768 + r_lim);
    lv_m = '0;
    for (int i = 1; i < 16; i++) begin
      if (lv[i]) lv_m = 4'(i);
    end
  end

  // log squaring step
  logic [31:0] sq_t;
  logic [19:0] l_full;
  assign sq_t   = prod[61:30];
  assign l_full = {lm_r, frac_r | (16'(sq_t[31]) << it_r[3:0])};

  // tanh argument
  logic signed [25:0] w_s;
  logic [24:0]        w_a;
  assign w_s = bsel_r ? ($signed({6'd0, d_r}) + $signed({2'd0, e_r}))
                      : ($signed({6'd0, d_r}) - $signed({2'd0, e_r}));
  assign w_a = w_s[25] ? 25'(-w_s) : 25'(w_s);

  // final power shift and tanh division operands
  logic [30:0] p_sh;
  logic [31:0] den;
  assign p_sh = (k_r >= 9'd31) ? 31'd0 : (p_r >> k_r[4:0]);
  assign den  = {1'b0, Q30_ONE} + {1'b0, p_sh};

  // clamped tanh result
  logic [15:0]        t_cl;
  logic signed [15:0] t_s;
  assign t_cl = (dq_r > 64'd32767) ? 16'd32767 : dq_r[15:0];
  assign t_s  = neg_r ? -$signed(t_cl) : $signed(t_cl);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc) state_nxt = in_cmd ? ST_SCAN : ST_UPD;
      ST_UPD:   state_nxt = ST_IDLE;
      ST_SCAN:  if (cnt_r == CNT_W'(KEY_COUNT)) state_nxt = few_r ? ST_OUT : ST_SQRT;
      ST_SQRT:  if (it_r == 6'd31) state_nxt = ST_EMUL;
      ST_EMUL:  state_nxt = ST_DIV;
      ST_DIV:   if (it_r == 6'd63) state_nxt = div_e_r ? ST_ESET : ST_TFIN;
      ST_ESET:  state_nxt = ST_LINIT;
      ST_LINIT: state_nxt = ST_LOG;
      ST_LOG:   if (it_r == 6'd0) state_nxt = lhalf_r ? ST_PINIT : ST_LINIT;
      ST_PINIT: state_nxt = ST_POW;
      ST_POW:   if (it_r == 6'd0) state_nxt = ST_PSH;
      ST_PSH:   state_nxt = ST_DIV;
      ST_TFIN: begin
        if (!bsel_r)     state_nxt = ST_PINIT;
        else if (!sel_r) state_nxt = ST_LINIT;
        else             state_nxt = ST_OUT;
      end
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state, quantile register, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r     <= QHW_RESET;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) h_r <= cfg_wdata;
      if (wr_en) vld_r[key_r] <= 1'b1;
      if (state_r == ST_SCAN && cnt_r == CNT_W'(KEY_COUNT)) vld_r <= '0;
    end
  end

  // peak store
  assign rd_addr = (state_r == ST_SCAN) ? cnt_r[KEY_W-1:0] : in_key_index;
  assign wr_en   = (state_r == ST_UPD) && (mag_r > cur_v);
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) mem[key_r] <= mag_r;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          key_r    <= in_key_index;
          mag_r    <= in_mag;
          n_r      <= in_trace_count;
          few_r    <= in_trace_count <= FEWEST_TRACES;
          cnt_r    <= '0;
          scan_v_r <= 1'b0;
          bv_r     <= '0;
          sv_r     <= '0;
          bi_r     <= '0;
          bl_r     <= '0;
          bh_r     <= '0;
          sl_r     <= '0;
          sh_r     <= '0;
        end
      end
      ST_SCAN: begin
        // top-two update on the beat read last cycle
        if (scan_v_r) begin
          if (cur_v > bv_r) begin
            sv_r <= bv_r;
            bv_r <= cur_v;
            bi_r <= scan_idx_r;
          end else if (cur_v > sv_r) begin
            sv_r <= cur_v;
          end
        end
        scan_idx_r <= cnt_r[KEY_W-1:0];
        if (cnt_r == CNT_W'(KEY_COUNT)) begin
          scan_v_r <= 1'b0;
          rem_r    <= 64'({n_r - FEWEST_TRACES, 30'd0});
          dq_r     <= '0;
          dv_r     <= 64'd1 << 62;
          it_r     <= '0;
        end else begin
          scan_v_r <= 1'b1;
          cnt_r    <= cnt_r + CNT_W'(1);
        end
      end
      ST_SQRT: begin
        if (ge) rem_r <= diff[63:0];
        dq_r <= ge ? ((dq_r >> 1) + dv_r) : (dq_r >> 1);
        dv_r <= dv_r >> 2;
        it_r <= it_r + 6'd1;
      end
      ST_EMUL: begin
        // numerator 2*h/ln2 with half-divisor rounding, divisor sqrt(n-3) << 11
        dq_r    <= (64'(prod) << 1) + (dq_r << 10);
        dv_r    <= dq_r << 11;
        rem_r   <= '0;
        it_r    <= '0;
        div_e_r <= 1'b1;
      end
      ST_DIV: begin
        rem_r <= ge ? diff[63:0] : cmp_a[63:0];
        dq_r  <= {dq_r[62:0], ge};
        it_r  <= it_r + 6'd1;
      end
      ST_ESET: begin
        e_r     <= dq_r[23:0];
        sel_r   <= 1'b0;
        lhalf_r <= 1'b0;
      end
      ST_LINIT: begin
        x_r    <= 31'(lv) << (5'd30 - {1'b0, lv_m});
        lm_r   <= lv_m;
        frac_r <= '0;
        it_r   <= 6'd15;
      end
      ST_LOG: begin
        x_r    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        frac_r <= l_full[15:0];
        it_r   <= it_r - 6'd1;
        if (it_r == 6'd0) begin
          if (!lhalf_r) begin
            la_r    <= l_full;
            lhalf_r <= 1'b1;
          end else begin
            d_r    <= la_r - l_full;
            bsel_r <= 1'b0;
          end
        end
      end
      ST_PINIT: begin
        neg_r <= w_s[25];
        a_r   <= w_a[15:0];
        k_r   <= w_a[24:16];
        p_r   <= Q30_ONE;
        it_r  <= 6'd15;
      end
      ST_POW: begin
        if (a_r[it_r[3:0]]) p_r <= prod[60:30];
        it_r <= it_r - 6'd1;
      end
      ST_PSH: begin
        dq_r    <= (64'(Q30_ONE - p_sh) << 15) + 64'(den >> 1);
        dv_r    <= 64'(den);
        rem_r   <= '0;
        it_r    <= '0;
        div_e_r <= 1'b0;
      end
      ST_TFIN: begin
        unique case ({sel_r, bsel_r})
          2'b00:   bl_r <= t_s;
          2'b01:   bh_r <= t_s;
          2'b10:   sl_r <= t_s;
          default: sh_r <= t_s;
        endcase
        if (!bsel_r) begin
          bsel_r <= 1'b1;
        end else begin
          sel_r   <= 1'b1;
          lhalf_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // result ports
  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = (state_r == ST_OUT);
  assign out_best_value     = bv_r;
  assign out_best_key       = 8'(bi_r);
  assign out_best_lower     = bl_r;
  assign out_best_upper     = bh_r;
  assign out_second_value   = sv_r;
  assign out_second_lower   = sl_r;
  assign out_second_upper   = sh_r;
  assign out_too_few_traces = few_r;
  assign out_traces_echo    = n_r;

  // checks
  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_few_traces |-> out_best_lower == 16'sd0 &&
      out_best_upper == 16'sd0 && out_second_lower == 16'sd0 && out_second_upper == 16'sd0)
    else $error("bounds not zero with too few traces");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_second_value <= out_best_value)
    else $error("second peak exceeds best peak");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
